>>> rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, widths and the CORDIC angle table for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  localparam int QW        = 16;
  localparam int OPW       = 36;
  localparam int ACC_W     = 30;
  localparam int ACC_FRAC  = 20;
  localparam int SQ_W      = 61;
  localparam int SQ_STEPS  = 31;
  localparam int ROOT_W    = 31;
  localparam int A_W       = 32;
  localparam int XZ_W      = 16;
  localparam int Y_W       = 15;
  localparam int TAB_LEN   = 24;

  typedef struct packed {
    logic signed [OPW-1:0]   x;
    logic signed [OPW-1:0]   y;
    logic signed [ACC_W-1:0] z;
    logic                    zero;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [33:0]    nx;
    logic signed [33:0]    ny;
    logic signed [33:0]    zx;
    logic signed [33:0]    zy;
    logic signed [A_W-1:0] a;
    logic                  clamped;
  } side_t;

  // atan(2^-i) in degrees, 20 fraction bits
  function automatic logic signed [ACC_W-1:0] atan_deg(input int i);
    case (i)
      0:       atan_deg = 30'sd47185920;
      1:       atan_deg = 30'sd27855475;
      2:       atan_deg = 30'sd14718068;
      3:       atan_deg = 30'sd7471121;
      4:       atan_deg = 30'sd3750058;
      5:       atan_deg = 30'sd1876857;
      6:       atan_deg = 30'sd938658;
      7:       atan_deg = 30'sd469357;
      8:       atan_deg = 30'sd234682;
      9:       atan_deg = 30'sd117342;
      10:      atan_deg = 30'sd58671;
      11:      atan_deg = 30'sd29335;
      12:      atan_deg = 30'sd14668;
      13:      atan_deg = 30'sd7334;
      14:      atan_deg = 30'sd3667;
      15:      atan_deg = 30'sd1833;
      16:      atan_deg = 30'sd917;
      17:      atan_deg = 30'sd458;
      18:      atan_deg = 30'sd229;
      19:      atan_deg = 30'sd115;
      20:      atan_deg = 30'sd57;
      21:      atan_deg = 30'sd29;
      22:      atan_deg = 30'sd14;
      23:      atan_deg = 30'sd7;
      default: atan_deg = '0;
    endcase
  endfunction

  // saturate to +-lim degrees, round half away from zero
  function automatic logic [XZ_W-1:0] finish_angle(
    input logic signed [ACC_W-1:0] acc,
    input logic                    zero,
    input logic signed [ACC_W-1:0] lim,
    input int                      sh
  );
    logic signed [ACC_W-1:0] a;
    logic [ACC_W-1:0]        mag;
    logic [ACC_W-1:0]        rnd;
    a = zero ? '0 : acc;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    rnd = (mag + (ACC_W'(1) << (sh - 1))) >> sh;
    finish_angle = a[ACC_W-1] ? XZ_W'(-rnd) : XZ_W'(rnd);
  endfunction

endpackage

`default_nettype wire

>>> rtl/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Q1.15 quaternion in, roll/pitch/yaw in fixed-point degrees out.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle while the pipe is not
// stalled. The pipe holds three product/sum stages, a 31-cell square root
// row for the asin cosine term, a quadrant fold, the CORDIC row and the output
// register. The whole pipe stalls only when the output register is full and
// not taken. asin_clamped travels in m_tuser.
`default_nettype none

module quaternion_to_euler_angles_top
  import qte_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // angle_x_deg, angle_y_deg, angle_z_deg, pad
  output logic [0:0]       m_tuser    // asin_clamped
);

  localparam int LAT = CORDIC_STAGES + 36;
  localparam int SH  = ACC_FRAC - ANGLE_FRAC_BITS;

  logic           en;
  logic [LAT-1:0] vld;

  logic signed [QW-1:0] qw, qx, qy, qz;
  logic signed [31:0]   p_ww, p_xx, p_yy, p_zz, p_yz, p_xw, p_xy, p_zw, p_yw, p_xz;

  side_t              s2, s3, s2_next;
  logic signed [33:0] a_raw;
  logic [SQ_W-1:0]    asq;
  logic signed [63:0] asq_full;

  side_t   sd [SQ_STEPS];
  sqrt_t   sq [SQ_STEPS];
  sqrt_t   sq_in;
  cordic_t lane [3][CORDIC_STAGES+1];
  logic    fl [CORDIC_STAGES+1];
  logic signed [OPW-1:0] c_op;

  logic [XZ_W-1:0] ax_f, az_f, ay_w;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= qw * qw;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_yz <= qy * qz;
      p_xw <= qx * qw;
      p_xy <= qx * qy;
      p_zw <= qz * qw;
      p_yw <= qy * qw;
      p_xz <= qx * qz;
    end
  end

  always_comb begin
    s2_next.nx = -34'(p_xx) - 34'(p_yy) + 34'(p_zz) + 34'(p_ww);
    s2_next.ny = (34'(p_yz) + 34'(p_xw)) <<< 1;
    s2_next.zx = 34'(p_xx) - 34'(p_yy) - 34'(p_zz) + 34'(p_ww);
    s2_next.zy = (34'(p_xy) + 34'(p_zw)) <<< 1;
    a_raw      = (34'(p_yw) - 34'(p_xz)) <<< 1;
    s2_next.clamped = 1'b0;
    s2_next.a  = A_W'(a_raw);
    if (a_raw > 34'sd1073741824) begin
      s2_next.a       = 32'sd1073741824;
      s2_next.clamped = 1'b1;
    end else if (a_raw < -34'sd1073741824) begin
      s2_next.a       = -32'sd1073741824;
      s2_next.clamped = 1'b1;
    end
  end

  assign asq_full = s2.a * s2.a;

  always_ff @(posedge clk) begin
    if (en) begin
      s2  <= s2_next;
      s3  <= s2;
      asq <= SQ_W'(asq_full);
    end
  end

  assign sq_in.n   = (SQ_W'(1) << 60) - asq;
  assign sq_in.res = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    qte_sqrt_cell #(.BIT_POS(60 - 2 * k)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  ((k == 0) ? sq_in : sq[(k == 0) ? 0 : k - 1]),
      .dout (sq[k])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sd[k] <= (k == 0) ? s3 : sd[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign c_op = OPW'(sq[SQ_STEPS-1].res[ROOT_W-1:0]);

  qte_prerot u_pre_x (
    .clk (clk), .en (en),
    .xin (OPW'(sd[SQ_STEPS-1].nx)), .yin (OPW'(sd[SQ_STEPS-1].ny)),
    .dout (lane[0][0])
  );
  qte_prerot u_pre_y (
    .clk (clk), .en (en),
    .xin (c_op), .yin (OPW'(sd[SQ_STEPS-1].a)),
    .dout (lane[1][0])
  );
  qte_prerot u_pre_z (
    .clk (clk), .en (en),
    .xin (OPW'(sd[SQ_STEPS-1].zx)), .yin (OPW'(sd[SQ_STEPS-1].zy)),
    .dout (lane[2][0])
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= sd[SQ_STEPS-1].clamped;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    for (genvar j = 0; j < 3; j++) begin : g_lane
      qte_cordic_cell #(.STAGE(i)) u_cell (
        .clk  (clk),
        .en   (en),
        .din  (lane[j][i]),
        .dout (lane[j][i+1])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1] <= fl[i];
      end
    end
  end

  assign ax_f = finish_angle(lane[0][CORDIC_STAGES].z, lane[0][CORDIC_STAGES].zero,
                             ACC_W'(180) <<< ACC_FRAC, SH);
  assign ay_w = finish_angle(lane[1][CORDIC_STAGES].z, lane[1][CORDIC_STAGES].zero,
                             ACC_W'(90) <<< ACC_FRAC, SH);
  assign az_f = finish_angle(lane[2][CORDIC_STAGES].z, lane[2][CORDIC_STAGES].zero,
                             ACC_W'(180) <<< ACC_FRAC, SH);

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= {1'b0, az_f, ay_w[Y_W-1:0], ax_f};
      m_tuser[0] <= fl[CORDIC_STAGES];
    end
  end

  logic signed [XZ_W-1:0] out_ax;
  logic signed [Y_W-1:0]  out_ay;
  assign out_ax = m_tdata[15:0];
  assign out_ay = m_tdata[30:16];

  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("pipe stalled with empty output register");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_ay <= (Y_W'(90) <<< ANGLE_FRAC_BITS)) &&
                 (out_ay >= -(Y_W'(90) <<< ANGLE_FRAC_BITS)))
    else $error("pitch beyond 90 degrees");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_ax <= (XZ_W'(180) <<< ANGLE_FRAC_BITS)) &&
                 (out_ax >= -(XZ_W'(180) <<< ANGLE_FRAC_BITS)))
    else $error("roll beyond 180 degrees");

endmodule

`default_nettype wire

>>> rtl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit step of the pipelined integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt_cell
  import qte_pkg::*;
#(
  parameter int BIT_POS = 60
) (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire sqrt_t din,
  output sqrt_t      dout
);

  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;
  sqrt_t           dout_next;

  assign bitv  = SQ_W'(1) << BIT_POS;
  assign trial = din.res + bitv;

  always_comb begin
    if (din.n >= trial) begin
      dout_next.n   = din.n - trial;
      dout_next.res = (din.res >> 1) + bitv;
    end else begin
      dout_next.n   = din.n;
      dout_next.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/qte_prerot.sv
// ----------------------------------------------------------------------------
// qte_prerot
// Quadrant fold ahead of the CORDIC row: turns a left half-plane vector by
// 90 degrees and marks the all-zero vector.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_prerot
  import qte_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [OPW-1:0] xin,
  input  wire logic signed [OPW-1:0] yin,
  output cordic_t                    dout
);

  cordic_t dout_next;

  always_comb begin
    dout_next.x    = xin;
    dout_next.y    = yin;
    dout_next.z    = '0;
    dout_next.zero = (xin == '0) && (yin == '0);
    if (xin[OPW-1]) begin
      if (!yin[OPW-1]) begin
        dout_next.x = yin;
        dout_next.y = -xin;
        dout_next.z = ACC_W'(90) <<< ACC_FRAC;
      end else begin
        dout_next.x = -yin;
        dout_next.y = xin;
        dout_next.z = -(ACC_W'(90) <<< ACC_FRAC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation with its angle accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic_cell
  import qte_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic    clk,
  input  wire logic    en,
  input  wire cordic_t din,
  output cordic_t      dout
);

  logic signed [OPW-1:0] xs;
  logic signed [OPW-1:0] ys;
  cordic_t               dout_next;

  assign xs = din.x >>> STAGE;
  assign ys = din.y >>> STAGE;

  always_comb begin
    dout_next.zero = din.zero;
    if (!din.y[OPW-1]) begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y - xs;
      dout_next.z = din.z + atan_deg(STAGE);
    end else begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y + xs;
      dout_next.z = din.z - atan_deg(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Quaternion to Euler angle converter: directed corner quaternions, then
// random requests, checked field by field against a bit-exact predictor
// with random idling on both stream sides, then a final phase without idling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = 7;
  localparam int STAGES   = 16;
  localparam int LATENCY  = STAGES + 36;
  localparam int LIMIT    = 400000;

  typedef struct {
    logic [15:0] ax;
    logic [14:0] ay;
    logic [15:0] az;
    logic        clamp;
  } euler_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;

  euler_t      pending[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 0;

  quaternion_to_euler_angles_top #(
    .ANGLE_FRAC_BITS(FRAC),
    .CORDIC_STAGES  (STAGES)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic longint atan_deg_tab(int i);
    longint t[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                      938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                      3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    return t[i];
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint vx, vy, ang, t, xs, ys;
    vx = xv;
    vy = yv;
    ang = 0;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; ang = 90 <<< 20;
      end else begin
        vx = -vy; vy = t; ang = -(90 <<< 20);
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx = vx + ys; vy = vy - xs; ang += atan_deg_tab(i);
      end else begin
        vx = vx - ys; vy = vy + xs; ang -= atan_deg_tab(i);
      end
    end
    return ang;
  endfunction

  function automatic longint round_deg(longint acc, longint lim_deg);
    longint lim, mag;
    int sh;
    lim = lim_deg <<< 20;
    sh = 20 - FRAC;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    mag = acc < 0 ? -acc : acc;
    mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    return acc < 0 ? -mag : mag;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic euler_t quat_to_euler(logic [63:0] q);
    longint w, x, y, z, a, c;
    euler_t e;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    e.clamp = 0;
    e.ax = 16'(round_deg(vector_angle(2 * (y * z + x * w),
                                      -x * x - y * y + z * z + w * w), 180));
    e.az = 16'(round_deg(vector_angle(2 * (x * y + z * w),
                                      x * x - y * y - z * z + w * w), 180));
    a = 2 * (y * w - x * z);
    if (a > (longint'(1) <<< 30)) begin
      a = longint'(1) <<< 30; e.clamp = 1;
    end
    if (a < -(longint'(1) <<< 30)) begin
      a = -(longint'(1) <<< 30); e.clamp = 1;
    end
    c = int_sqrt((64'd1 << 60) - longint'(a * a));
    e.ay = 15'(round_deg(vector_angle(a, c), 90));
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    euler_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        e = pending.pop_front();
        if (m_tdata[15:0] !== e.ax) report_mismatch("angle_x", m_tdata[15:0], e.ax);
        if (m_tdata[30:16] !== e.ay) report_mismatch("angle_y", m_tdata[30:16], e.ay);
        if (m_tdata[46:31] !== e.az) report_mismatch("angle_z", m_tdata[46:31], e.az);
        if (m_tuser[0] !== e.clamp) report_mismatch("asin_clamped", m_tuser[0], e.clamp);
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    m_tready <= 0;
    @(posedge clk iff !rst);
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        m_tready <= 1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 18);
        m_tready <= 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 18);
      s_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    s_tdata  <= {z, y, x, w};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending.push_back(quat_to_euler({z, y, x, w}));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic test_corners();
    logic [15:0] v[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                          16'h5A82};
    send_quat(16'h7FFF, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h5A82, 0, 16'h5A82, 0);
    send_quat(16'h5A82, 0, 16'hA57E, 0);
    send_quat(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_quat(0, 16'h7FFF, 0, 0);
    send_quat(0, 0, 0, 16'h8000);
    send_quat(16'h8000, 0, 0, 0);
    for (int i = 0; i < 12; i++)
      send_quat(v[$urandom_range(0, 5)], v[$urandom_range(0, 5)],
                v[$urandom_range(0, 5)], v[$urandom_range(0, 5)]);
    drain();
  endtask

  task automatic test_unit_quats(int count);
    real a, b, c, d, nrm;
    for (int i = 0; i < count; i++) begin
      a = $itor($signed(16'($urandom()))); b = $itor($signed(16'($urandom())));
      c = $itor($signed(16'($urandom()))); d = $itor($signed(16'($urandom())));
      nrm = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      send_quat(16'($rtoi(a / nrm * 32767.0)), 16'($rtoi(b / nrm * 32767.0)),
                16'($rtoi(c / nrm * 32767.0)), 16'($rtoi(d / nrm * 32767.0)));
    end
  endtask

  task automatic test_raw_quats(int count);
    for (int i = 0; i < count; i++)
      send_quat(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_corners();
    test_unit_quats(300);
    test_raw_quats(150);
    drain();
    quiet = 1;
    test_unit_quats(60);
    test_raw_quats(40);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
